// ===== rtl/dpks_pkg.sv =====
// Package for the dot-product top-K search unit.
// Holds transaction types, queue types, back-end state codes and shared constants.
// No dependencies.
`default_nettype none

package dpks_pkg;

  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned KCFG_W    = 5;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'd32768;

  // One input transaction: a pair of Q1.15 elements plus framing flags.
  typedef struct packed {
    logic signed [15:0] query_value;
    logic signed [15:0] entry_value;
    logic               last_in_entry;
    logic               last_entry;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [INDEX_W-1:0] entry_index;
    logic [SCORE_W-1:0] score;
    logic               last_result;
  } out_item_t;

  // A finished entry score travelling from the front end to the back end.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] entry_index;
    logic               end_run;
  } cand_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_e;

endpackage

`default_nettype wire

// ===== rtl/dpks_front.sv =====
// Front end of the dot-product top-K search unit: multiply, saturating accumulate, score.
// Depends on dpks_pkg. Feeds finished entry scores into dpks_fifo.
`default_nettype none

module dpks_front import dpks_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  input  wire q_stat_t  q_stat_i,
  output logic          busy_o,
  output logic          push_o,
  output cand_t         cand_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);
  localparam int unsigned OCC_W = QCNT_W + 1;
  localparam int unsigned SUM_W = ACC_W + 1;

  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic                     s1_last_q;
  logic                     s1_run_q;

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic [SUM_W-1:0]         sum;
  logic [ACC_W-1:0]         sat;
  logic [SCORE_W-1:0]       score;
  logic [OCC_W-1:0]         occupancy;

  // Count the queue slots already taken plus the score that stage two may push.
  assign occupancy = {1'b0, q_stat_i.count} + {{QCNT_W{1'b0}}, (s1_valid_q & s1_last_q)};
  assign busy_o    = (occupancy >= OCC_W'(QDEPTH));

  // Stage one: the product register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_prod_q <= item_i.query_value * item_i.entry_value;
      s1_last_q <= item_i.last_in_entry;
      s1_run_q  <= item_i.last_in_entry & item_i.last_entry;
    end
  end

  // Stage two: saturating accumulate and score finish.
  always_comb begin
    sum = {acc_q[ACC_W-1], acc_q} + {{(SUM_W-PROD_W){s1_prod_q[PROD_W-1]}}, s1_prod_q};
    unique case (sum[SUM_W-1:SUM_W-2])
      2'b01:   sat = {1'b0, {(ACC_W-1){1'b1}}};
      2'b10:   sat = {1'b1, {(ACC_W-1){1'b0}}};
      default: sat = sum[ACC_W-1:0];
    endcase

    if (sat[ACC_W-1] || (sat == '0)) begin
      score = '0;
    end else if (|sat[ACC_W-2:30]) begin
      score = SCORE_ONE;
    end else begin
      score = sat[30:15];
    end

    acc_d  = acc_q;
    idx_d  = idx_q;
    push_o = 1'b0;
    if (s1_valid_q) begin
      if (s1_last_q) begin
        acc_d  = '0;
        push_o = 1'b1;
        if (s1_run_q) begin
          idx_d = '0;
        end else if (idx_q != IDX_LAST) begin
          idx_d = idx_q + 1'b1;
        end
      end else begin
        acc_d = sat;
      end
    end

    cand_o.score       = score;
    cand_o.entry_index = INDEX_W'(idx_q);
    cand_o.end_run     = s1_run_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      idx_q <= '0;
    end else begin
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpks_fifo.sv =====
// Short candidate queue between the front end and the back end.
// Depends on dpks_pkg for the candidate type and queue depth.
`default_nettype none

module dpks_fifo import dpks_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cand_t data_i,
  input  wire logic  pop_i,
  output cand_t      data_o,
  output q_stat_t    stat_o
);

  cand_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpks_back.sv =====
// Back end of the dot-product top-K search unit: sorted best-K list and result emission.
// Depends on dpks_pkg. Pops candidates from dpks_fifo.
`default_nettype none

module dpks_back import dpks_pkg::*; #(
  parameter int unsigned MAX_K = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [KCFG_W-1:0]  top_k_count_i,
  input  wire q_stat_t            q_stat_i,
  input  wire cand_t              cand_i,
  output logic                    pop_o,
  output logic                    result_valid_o,
  output out_item_t               result_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_K + 1);
  localparam int unsigned SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KW     = (CNT_W > KCFG_W) ? CNT_W : KCFG_W;

  bk_state_e          state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   left_q, left_d;
  logic [SCORE_W-1:0] slot_score_q [MAX_K];
  logic [INDEX_W-1:0] slot_index_q [MAX_K];

  logic [CNT_W-1:0]   eff_k;
  logic               list_full;
  logic [MAX_K-1:0]   gt;
  logic [SLOT_W-1:0]  tail_slot;
  logic               insert;
  logic               shift_out;
  logic [CNT_W-1:0]   count_new;
  logic [CNT_W-1:0]   emit_n;
  logic               res_valid_q, res_valid_d;
  out_item_t          res_q;

  assign eff_k = (KW'(top_k_count_i) > KW'(MAX_K)) ? CNT_W'(MAX_K) : CNT_W'(top_k_count_i);
  assign list_full = (count_q >= eff_k);
  assign tail_slot = SLOT_W'(count_q - 1'b1);

  // Slots past the fill level always give way to the new score.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cmp
    assign gt[i] = (CNT_W'(i) < count_q) ? (cand_i.score > slot_score_q[i]) : 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    pop_o       = 1'b0;
    insert      = 1'b0;
    shift_out   = 1'b0;
    res_valid_d = 1'b0;
    count_new   = count_q;
    emit_n      = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          insert = (eff_k != '0) && (!list_full || gt[tail_slot]);
          if (insert && !list_full) begin
            count_new = count_q + 1'b1;
          end
          count_d = count_new;
          if (cand_i.end_run) begin
            emit_n  = (count_new < eff_k) ? count_new : eff_k;
            count_d = '0;
            left_d  = emit_n;
            if (emit_n != '0) begin
              state_d = BK_EMIT;
            end
          end
        end
      end
      BK_EMIT: begin
        shift_out   = 1'b1;
        res_valid_d = 1'b1;
        left_d      = left_q - 1'b1;
        if (left_q == CNT_W'(1)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Parallel insertion into the descending list, or a shift toward slot zero while emitting.
  for (genvar i = 0; i < MAX_K; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (insert && gt[i]) begin
        if (i == 0) begin
          slot_score_q[i] <= cand_i.score;
          slot_index_q[i] <= cand_i.entry_index;
        end else if (!gt[(i > 0) ? i - 1 : 0]) begin
          slot_score_q[i] <= cand_i.score;
          slot_index_q[i] <= cand_i.entry_index;
        end else begin
          slot_score_q[i] <= slot_score_q[(i > 0) ? i - 1 : 0];
          slot_index_q[i] <= slot_index_q[(i > 0) ? i - 1 : 0];
        end
      end else if (shift_out && (i < MAX_K - 1)) begin
        slot_score_q[i] <= slot_score_q[(i < MAX_K - 1) ? i + 1 : i];
        slot_index_q[i] <= slot_index_q[(i < MAX_K - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_out) begin
      res_q.entry_index <= slot_index_q[0];
      res_q.score       <= slot_score_q[0];
      res_q.last_result <= (left_q == CNT_W'(1));
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/dot_product_top_k_search_unit.sv =====
// Top level of the dot-product top-K search unit.
// Depends on dpks_pkg, dpks_front, dpks_fifo and dpks_back.
`default_nettype none

// The unit takes one element pair per transaction (start high while busy is low) and
// accumulates a saturating Q18.30 dot product per entry; the front end sustains one
// transaction per cycle while busy is low through a multiplier stage and an accumulator
// stage. Each entry's clamped score crosses a four-deep queue to the back end, which
// inserts it into a sorted list of the best entries. When the final entry of a run
// arrives, the back end emits min(K, entries) results with K capped at MAX_K, best first,
// one per cycle on consecutive cycles with result_valid_o high; the last one carries
// last_result. The receiver cannot stall these results, so it must take each on the
// cycle it appears. While results stream out the front end keeps accumulating the next
// run, and busy rises once the finished entry scores queued or about to be pushed fill
// the queue. Writing top_k_count takes effect for entries scored afterwards and is meant
// to happen only while the unit is idle.

module dot_product_top_k_search_unit import dpks_pkg::*; #(
  parameter int unsigned MAX_K       = 16,
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [KCFG_W-1:0] cfg_wdata_i,
  output logic                   result_valid_o,
  output out_item_t              result_o
);

  logic [KCFG_W-1:0] top_k_count_q;
  logic              accept;
  logic              q_push;
  logic              q_pop;
  cand_t             q_wdata;
  cand_t             q_rdata;
  q_stat_t           q_stat;

  // The configuration register resets to one best entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_count_q <= KCFG_W'(1);
    end else if (cfg_we_i) begin
      top_k_count_q <= cfg_wdata_i;
    end
  end

  assign accept = start & ~busy;

  dpks_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .q_stat_i (q_stat),
    .busy_o   (busy),
    .push_o   (q_push),
    .cand_o   (q_wdata)
  );

  dpks_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  dpks_back #(
    .MAX_K (MAX_K)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .top_k_count_i  (top_k_count_q),
    .q_stat_i       (q_stat),
    .cand_i         (q_rdata),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // The front end's credit check must keep the queue from overflowing.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (!q_stat.full || q_pop))
    else $error("candidate pushed into a full queue");

  // A full queue must hold off new transactions.
  a_busy_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> busy)
    else $error("queue full but unit not busy");

  // The back end never pops an empty queue.
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("candidate popped from an empty queue");

  // After a run's final result the result strobe drops low.
  a_gap_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !result_valid_o)
    else $error("result strobe right after the last result of a run");

endmodule

`default_nettype wire

// ===== tb/topk_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the dot-product top-K search unit: watches the transaction,
// configuration and result channels, predicts the ranked results and compares them.
// Depends on dpks_pkg for the transaction types and widths.

module topk_result_checker import dpks_pkg::*; #(
  parameter int unsigned MAX_K       = 16,
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire in_item_t          item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [KCFG_W-1:0] cfg_wdata_i,
  input  wire logic              result_valid_i,
  input  wire out_item_t         result_i,
  output int                     pending_o,
  output int                     mismatch_count_o
);

  localparam longint ACC_HI  = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_LO  = -ACC_HI - 64'sd1;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  logic [KCFG_W-1:0]  k_reg;
  longint             dot_sum;
  int unsigned        entry_pos;
  logic [SCORE_W-1:0] kept_score [MAX_K];
  logic [INDEX_W-1:0] kept_index [MAX_K];
  int unsigned        kept_count;
  out_item_t          expected_hits [$];

  function automatic int unsigned active_k();
    return (k_reg > MAX_K) ? MAX_K : int'(k_reg);
  endfunction

  // Positive sums below one keep their upper bits; the rest clamp to zero or one.
  function automatic logic [SCORE_W-1:0] clamp_score(longint sum);
    longint shifted;
    if (sum <= 0) return '0;
    if (sum >= ONE_Q30) return SCORE_ONE;
    shifted = sum >>> 15;
    return shifted[SCORE_W-1:0];
  endfunction

  // Keeps the list sorted by score descending; equal scores stay in arrival order.
  function automatic void rank_insert(logic [SCORE_W-1:0] s, logic [INDEX_W-1:0] idx);
    int unsigned k;
    int unsigned pos;
    k = active_k();
    if (k == 0) return;
    if (kept_count < k) begin
      kept_count++;
    end else if (s <= kept_score[kept_count-1]) begin
      return;
    end
    pos = kept_count - 1;
    while (pos > 0 && kept_score[pos-1] < s) begin
      kept_score[pos] = kept_score[pos-1];
      kept_index[pos] = kept_index[pos-1];
      pos--;
    end
    kept_score[pos] = s;
    kept_index[pos] = idx;
  endfunction

  function automatic void absorb_item(in_item_t it);
    longint      prod;
    int unsigned n;
    out_item_t   hit;
    prod = longint'($signed(it.query_value)) * longint'($signed(it.entry_value));
    dot_sum = dot_sum + prod;
    if (dot_sum > ACC_HI) dot_sum = ACC_HI;
    if (dot_sum < ACC_LO) dot_sum = ACC_LO;
    if (!it.last_in_entry) return;
    rank_insert(clamp_score(dot_sum), entry_pos[INDEX_W-1:0]);
    dot_sum = 0;
    if (entry_pos < MAX_ENTRIES - 1) entry_pos++;
    if (!it.last_entry) return;
    n = (kept_count < active_k()) ? kept_count : active_k();
    for (int unsigned r = 0; r < n; r++) begin
      hit.entry_index = kept_index[r];
      hit.score       = kept_score[r];
      hit.last_result = (r + 1 == n);
      expected_hits   = {expected_hits, hit};
    end
    entry_pos  = 0;
    kept_count = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  initial begin
    pending_o        = 0;
    mismatch_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      k_reg      = 5'd1;
      dot_sum    = 0;
      entry_pos  = 0;
      kept_count = 0;
      expected_hits.delete();
    end else begin
      if (result_valid_i === 1'b1) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d score %0d last %0b",
                                    result_i.entry_index, result_i.score,
                                    result_i.last_result));
        end else begin
          want = expected_hits.pop_front();
          if (result_i.entry_index !== want.entry_index)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      result_i.entry_index, want.entry_index));
          if (result_i.score !== want.score)
            report_mismatch($sformatf("score %0d, expected %0d (index %0d)",
                                      result_i.score, want.score, want.entry_index));
          if (result_i.last_result !== want.last_result)
            report_mismatch($sformatf("last_result %0b, expected %0b (index %0d)",
                                      result_i.last_result, want.last_result,
                                      want.entry_index));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) absorb_item(item_i);
      if (cfg_we_i === 1'b1) k_reg = cfg_wdata_i;
    end
    pending_o = expected_hits.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the dot-product top-K search unit: clock, reset, stimulus
// and the final verdict. Depends on dpks_pkg, the unit itself and topk_result_checker.

module tb;
  import dpks_pkg::*;

  localparam int unsigned MAX_K        = 16;
  localparam int unsigned MAX_ENTRIES  = 65536;
  localparam int          RANDOM_ITEMS = 100;
  // Wait after the last result has gone out, for the pipeline, the score queue and one
  // insertion per queued entry to settle.
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 200000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          item;
  logic              cfg_we;
  logic [KCFG_W-1:0] cfg_wdata;
  logic              result_valid;
  out_item_t         result;
  int                pending;
  int                fail_count;
  int                cycles;
  int                sent_count;
  int                directed_count;
  bit                gaps_on;

  dot_product_top_k_search_unit #(
    .MAX_K       (MAX_K),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  // The checker sits beside the unit and sees the same pins; it owns all prediction.
  topk_result_checker #(
    .MAX_K       (MAX_K),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .item_i           (item),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .result_valid_i   (result_valid),
    .result_i         (result),
    .pending_o        (pending),
    .mismatch_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drives one element-pair transaction and returns at the edge that accepts it. Start is
  // left high so that a following call can hand over the next transaction back to back;
  // a random idle burst lowers it for a while.
  task automatic send_pair(input logic signed [15:0] q, input logic signed [15:0] e,
                           input logic end_entry, input logic end_run);
    in_item_t nxt;
    nxt.query_value   = q;
    nxt.entry_value   = e;
    nxt.last_in_entry = end_entry;
    nxt.last_entry    = end_run;
    item  <= nxt;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Waits until every predicted result has come out, then lets the back end finish any
  // insertion that produces no result of its own (an entry inside a run, or a run that
  // reports nothing).
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The register may only change while the unit is idle, so every write settles first.
  task automatic write_k(input logic [KCFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Value styles: full random, range extremes, moderate non-negatives that keep scores
  // below one, and a coarse grid that makes equal scores common.
  function automatic logic signed [15:0] pick_value(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return 16'sh0001;
          default: return 16'shffff;
        endcase
      end
      2: return 16'($urandom_range(0, 8191));
      default: return 16'($urandom_range(0, 3) * 1024);
    endcase
  endfunction

  // One well-formed search run with random content. Occasionally a stray last_entry rides
  // on an element that does not end its entry; the unit must ignore it.
  task automatic send_run(input int n_entries, input int mode);
    int  len;
    bit  stray;
    for (int en = 0; en < n_entries; en++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
      for (int el = 0; el < len; el++) begin
        if (el + 1 < len) begin
          stray = ($urandom_range(0, 9) == 0);
          send_pair(pick_value(mode), pick_value(mode), 1'b0, stray);
        end else begin
          send_pair(pick_value(mode), pick_value(mode), 1'b1, en + 1 == n_entries);
        end
      end
    end
  endtask

  initial begin
    int        n_entries;
    int        mode;
    logic [KCFG_W-1:0] k_pick;
    logic [KCFG_W-1:0] k_list [8];
    k_list = '{5'd0, 5'd1, 5'd2, 5'd4, 5'd7, 5'd16, 5'd17, 5'd31};
    rst_n      = 1'b0;
    start      = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    cycles     = 0;
    sent_count = 0;
    gaps_on    = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset value of one, only the best entry comes out. The second entry
    // multiplies the two most negative values and clamps at exactly one.
    send_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b1);

    // Full depth: a negative sum, a zero sum, a tie at 8192 reached by one and by two
    // elements (with a stray last_entry in between), a sum past one, and a positive sum
    // that truncates to zero.
    write_k(5'd16);
    send_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
    send_pair(16'sh0000, 16'sd12345, 1'b1, 1'b0);
    send_pair(16'sd16384, 16'sd16384, 1'b1, 1'b0);
    send_pair(16'sd16384, 16'sd8192, 1'b0, 1'b1);
    send_pair(16'sd16384, 16'sd8192, 1'b1, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b0, 1'b0);
    send_pair(16'sd16384, 16'sd3, 1'b1, 1'b1);

    // A full list of two: an equal score is not strictly greater and is dropped, a higher
    // one evicts the lowest-ranked entry.
    write_k(5'd2);
    send_pair(16'sd16384, 16'sd10000, 1'b1, 1'b0);
    send_pair(16'sd16384, 16'sd10000, 1'b1, 1'b0);
    send_pair(16'sd16384, 16'sd10000, 1'b1, 1'b0);
    send_pair(16'sd16384, 16'sd12000, 1'b1, 1'b1);

    // K lowered in the middle of a run: the last insertion and the report use the new value.
    write_k(5'd3);
    send_pair(16'sd16384, 16'sd4000, 1'b1, 1'b0);
    send_pair(16'sd16384, 16'sd2000, 1'b1, 1'b0);
    write_k(5'd1);
    send_pair(16'sd16384, 16'sd3000, 1'b1, 1'b1);

    // K of zero keeps nothing, and the run still clears.
    write_k(5'd0);
    send_pair(16'sd16384, 16'sd100, 1'b1, 1'b1);

    // A value above the list depth acts as the full depth.
    write_k(5'd31);
    send_pair(16'sd12345, 16'sd23456, 1'b1, 1'b0);
    send_pair(-16'sd5, 16'sd7, 1'b1, 1'b1);
    directed_count = sent_count;

    // Random runs, mostly short ones. Long runs of one-element entries under a deep list
    // fill the score queue while results stream out, which is what makes busy rise. The
    // last fifth of the stimulus runs without idle bursts and without register writes.
    while (sent_count - directed_count < RANDOM_ITEMS) begin
      gaps_on   = (sent_count - directed_count < RANDOM_ITEMS * 4 / 5);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        k_pick = $urandom_range(0, 1) ? k_list[$urandom_range(0, 7)]
                                      : 5'($urandom_range(0, 31));
        write_k(k_pick);
      end
      n_entries = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 24)
                                              : $urandom_range(1, 6);
      mode      = $urandom_range(0, 3);
      send_run(n_entries, mode);
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== dot_product_top_k_search_unit.f =====
rtl/dpks_pkg.sv
rtl/dpks_front.sv
rtl/dpks_fifo.sv
rtl/dpks_back.sv
rtl/dot_product_top_k_search_unit.sv
tb/topk_result_checker.sv
tb/tb.sv
